@@ rtl/hmsa_pkg.sv @@
// Shared opcodes, time constants and the flag bundle for the hours-minutes-seconds unit
package hmsa_pkg;
	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_INC  = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_MUL  = 3'd4;
	localparam logic [2:0] OP_DIV  = 3'd5;

	localparam int FIELD_W        = 17;
	localparam int HOURS_W        = 21;
	localparam int MS_W           = 7;
	localparam int SEC_PER_HOUR   = 3600;
	localparam int SEC_PER_MIN    = 60;
	localparam int HOUR_REM_W     = 12;
	// floor(r * MIN_RECIP / 2^MIN_RECIP_SHIFT) == r / 60 for every r below 3600
	localparam int MIN_RECIP      = 4370;
	localparam int MIN_RECIP_SHIFT = 18;
	localparam int MIN_PROD_W     = 25;

	// Split by 3600 one byte of the total at a time. 3600 = 16 * 225: drop the
	// low four bits, then floor(y * HOUR_RECIP / 2^HOUR_RECIP_SHIFT) == y / 225
	// for every 16-bit y.
	localparam int HOUR_DIGIT_W     = 8;
	localparam int HOUR_PRE_SHIFT   = 4;
	localparam int HOUR_RECIP       = 74566;
	localparam int HOUR_RECIP_SHIFT = 24;
	localparam int HOUR_PROD_W      = 33;

	typedef struct packed {
		logic a_greater;
		logic a_less;
		logic a_equal;
		logic div_by_zero;
	} hmsa_flags_t;
endpackage

@@ rtl/hms_time_arithmetic_unit.sv @@
// Top level of the hours-minutes-seconds time arithmetic unit
//
//  channel   direction  handshake          payload
//  command   in         start / busy       opcode, a_*, b_*, scalar
//  result    out        done (one cycle)   res_hours, res_minutes, res_seconds, flags
//
// From acceptance to done an item passes front-end stages s1 and s2, the queue, the
// back-end input register, the pipelined divider by the scalar (one quotient bit per
// stage), a register, the split by 3600 (one byte of the total per stage) and done_q.
// One item is taken per cycle while busy is low; results leave in order, one per cycle.
// arst_n clears every valid bit and the queue pointers; data registers keep junk.
// The receiver cannot stall, so the back end drains the queue every cycle and
// busy rises only if the queue fills.
module hms_time_arithmetic_unit #(
	parameter int TOTAL_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        opcode,
	input  logic signed [16:0] a_hours,
	input  logic signed [16:0] a_minutes,
	input  logic signed [16:0] a_seconds,
	input  logic signed [16:0] b_hours,
	input  logic signed [16:0] b_minutes,
	input  logic signed [16:0] b_seconds,
	input  logic signed [16:0] scalar,
	output logic              done,
	output logic signed [20:0] res_hours,
	output logic signed [6:0] res_minutes,
	output logic signed [6:0] res_seconds,
	output logic              a_greater,
	output logic              a_less,
	output logic              a_equal,
	output logic              div_by_zero
);
	localparam int QW = TOTAL_WIDTH + 17 + 1 + 4;

	logic                  push, full, pop, empty;
	logic [TOTAL_WIDTH-1:0] push_value, pop_value;
	logic [16:0]           push_scalar, pop_scalar;
	logic                  push_is_div, pop_is_div;
	hmsa_pkg::hmsa_flags_t push_flags, pop_flags, res_flags;

	// Front end: totals, compare flags and the operations other than division
	hmsa_front #(.TW(TOTAL_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.a_hours     (a_hours),
		.a_minutes   (a_minutes),
		.a_seconds   (a_seconds),
		.b_hours     (b_hours),
		.b_minutes   (b_minutes),
		.b_seconds   (b_seconds),
		.scalar      (scalar),
		.full        (full),
		.push        (push),
		.push_value  (push_value),
		.push_scalar (push_scalar),
		.push_is_div (push_is_div),
		.push_flags  (push_flags)
	);

	// Hold classified items until the back end takes them
	hmsa_queue #(.W(QW), .DEPTH(2)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data ({push_value, push_scalar, push_is_div, push_flags}),
		.full    (full),
		.rd_en   (pop),
		.rd_data ({pop_value, pop_scalar, pop_is_div, pop_flags}),
		.empty   (empty)
	);

	// Back end: division and the split into hours, minutes and seconds
	hmsa_back #(.TW(TOTAL_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.pop         (pop),
		.in_value    (pop_value),
		.in_scalar   (pop_scalar),
		.in_is_div   (pop_is_div),
		.in_flags    (pop_flags),
		.done        (done),
		.res_hours   (res_hours),
		.res_minutes (res_minutes),
		.res_seconds (res_seconds),
		.res_flags   (res_flags)
	);

	assign a_greater   = res_flags.a_greater;
	assign a_less      = res_flags.a_less;
	assign a_equal     = res_flags.a_equal;
	assign div_by_zero = res_flags.div_by_zero;
endmodule

@@ rtl/hmsa_front.sv @@
// Front end: convert operands to total seconds, classify and run the short operations
module hmsa_front #(
	parameter int TW = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               opcode,
	input  logic signed [16:0]       a_hours,
	input  logic signed [16:0]       a_minutes,
	input  logic signed [16:0]       a_seconds,
	input  logic signed [16:0]       b_hours,
	input  logic signed [16:0]       b_minutes,
	input  logic signed [16:0]       b_seconds,
	input  logic signed [16:0]       scalar,
	input  logic                     full,
	output logic                     push,
	output logic [TW-1:0]            push_value,
	output logic [16:0]              push_scalar,
	output logic                     push_is_div,
	output hmsa_pkg::hmsa_flags_t    push_flags
);
	logic signed [31:0] ta_sum, tb_sum;
	logic               accept, adv2;

	logic               v_s1;
	logic [2:0]         op_s1;
	logic signed [TW-1:0] ta_s1, tb_s1;
	logic signed [16:0] sc_s1;

	logic signed [TW+16:0] prod;
	logic signed [TW-1:0]  val;
	hmsa_pkg::hmsa_flags_t flags;

	logic               v_s2;
	logic [TW-1:0]      val_s2;
	logic [16:0]        sc_s2;
	logic               is_div_s2;
	hmsa_pkg::hmsa_flags_t flags_s2;

	assign ta_sum = 32'(a_hours) * 32'(hmsa_pkg::SEC_PER_HOUR)
		+ 32'(a_minutes) * 32'(hmsa_pkg::SEC_PER_MIN) + 32'(a_seconds);
	assign tb_sum = 32'(b_hours) * 32'(hmsa_pkg::SEC_PER_HOUR)
		+ 32'(b_minutes) * 32'(hmsa_pkg::SEC_PER_MIN) + 32'(b_seconds);

	assign push   = v_s2 && !full;
	assign adv2   = !v_s2 || push;
	assign busy   = v_s1 && !adv2;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || adv2) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= opcode;
			ta_s1 <= TW'(ta_sum);
			tb_s1 <= TW'(tb_sum);
			sc_s1 <= scalar;
		end
	end

	assign prod = ta_s1 * sc_s1;

	always_comb begin
		case (op_s1)
			hmsa_pkg::OP_INC: val = ta_s1 + TW'(1);
			hmsa_pkg::OP_ADD: val = ta_s1 + tb_s1;
			hmsa_pkg::OP_SUB: val = ta_s1 - tb_s1;
			hmsa_pkg::OP_MUL: val = prod[TW-1:0];
			default:          val = ta_s1;
		endcase
		flags.a_greater   = ta_s1 > tb_s1;
		flags.a_less      = ta_s1 < tb_s1;
		flags.a_equal     = ta_s1 == tb_s1;
		flags.div_by_zero = (op_s1 == hmsa_pkg::OP_DIV) && (sc_s1 == 17'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			val_s2    <= val;
			sc_s2     <= sc_s1;
			is_div_s2 <= op_s1 == hmsa_pkg::OP_DIV;
			flags_s2  <= flags;
		end
	end

	assign push_value  = val_s2;
	assign push_scalar = sc_s2;
	assign push_is_div = is_div_s2;
	assign push_flags  = flags_s2;
endmodule

@@ rtl/hmsa_queue.sv @@
// Small register queue between the front end and the back end
module hmsa_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = count_q == (PW+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

@@ rtl/hmsa_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, a tag rides alongside
module hmsa_div #(
	parameter int W  = 32,
	parameter int DW = 17,
	parameter int PW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	input  logic [PW-1:0] in_tag,
	output logic          out_valid,
	output logic [W-1:0]  quotient,
	output logic [PW-1:0] out_tag
);
	logic          v_s   [W+1];
	logic [W-1:0]  num_s [W+1];
	logic [DW-1:0] rem_s [W+1];
	logic [DW-1:0] dvs_s [W+1];
	logic [PW-1:0] tag_s [W+1];

	assign v_s[0]   = in_valid;
	assign num_s[0] = dividend;
	assign rem_s[0] = '0;
	assign dvs_s[0] = divisor;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          ge;

		assign trial = {rem_s[k], num_s[k][W-1]};
		assign diff  = {1'b0, trial} - {2'b00, dvs_s[k]};
		assign ge    = !diff[DW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1] <= {num_s[k][W-2:0], ge};
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			dvs_s[k+1] <= dvs_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = v_s[W];
	assign quotient  = num_s[W];
	assign out_tag   = tag_s[W];
endmodule

@@ rtl/hmsa_back.sv @@
// Back end: scalar division, split of the total into hours, minutes and seconds
module hmsa_back #(
	parameter int TW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	output logic                        pop,
	input  logic [TW-1:0]               in_value,
	input  logic [16:0]                 in_scalar,
	input  logic                        in_is_div,
	input  hmsa_pkg::hmsa_flags_t       in_flags,
	output logic                        done,
	output logic signed [20:0]          res_hours,
	output logic signed [6:0]           res_minutes,
	output logic signed [6:0]           res_seconds,
	output hmsa_pkg::hmsa_flags_t       res_flags
);
	localparam int RW = hmsa_pkg::HOUR_REM_W;
	localparam int DG = hmsa_pkg::HOUR_DIGIT_W;
	localparam int ND = (TW + DG - 1) / DG;
	localparam int NB = ND * DG;
	localparam int PS = hmsa_pkg::HOUR_PRE_SHIFT;

	logic          neg_in, dz_in;
	logic [TW-1:0] mag_in;
	logic [16:0]   dvs_in;

	logic                  v_b1, neg_b1;
	logic [TW-1:0]         mag_b1;
	logic [16:0]           dvs_b1;
	hmsa_pkg::hmsa_flags_t flags_b1;

	logic                  v_d1;
	logic [TW-1:0]         q_d1;
	logic [4:0]            tag_d1;

	logic [TW-1:0]         res_d1, mag_d1;

	logic                  v_b2, neg_b2;
	logic [TW-1:0]         mag_b2;
	hmsa_pkg::hmsa_flags_t flags_b2;

	logic                  hv_s   [ND+1];
	logic [NB-1:0]         hnum_s [ND+1];
	logic [RW-1:0]         hrem_s [ND+1];
	logic [4:0]            htag_s [ND+1];

	logic [NB-1:0]                   hrs_signed;
	logic [hmsa_pkg::MIN_PROD_W-1:0] min_prod;
	logic [5:0]                      mins;
	logic [RW-1:0]                   secs;

	logic                  done_q;
	logic [20:0]           hours_q;
	logic [6:0]            minutes_q, seconds_q;
	hmsa_pkg::hmsa_flags_t flags_q;

	assign pop   = !empty;
	assign dz_in = in_flags.div_by_zero;

	// Signs and magnitudes; non-divide and divide-by-zero items go through the divider over one
	always_comb begin
		mag_in = in_value[TW-1] ? TW'(-in_value) : in_value;
		if (dz_in) begin
			neg_in = 1'b0;
			mag_in = '0;
			dvs_in = 17'd1;
		end else if (in_is_div) begin
			neg_in = in_value[TW-1] ^ in_scalar[16];
			dvs_in = in_scalar[16] ? 17'(-in_scalar) : in_scalar;
		end else begin
			neg_in = in_value[TW-1];
			dvs_in = 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else begin
			v_b1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		neg_b1   <= neg_in;
		mag_b1   <= mag_in;
		dvs_b1   <= dvs_in;
		flags_b1 <= in_flags;
	end

	hmsa_div #(.W(TW), .DW(17), .PW(5)) u_div_scalar (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_b1),
		.dividend  (mag_b1),
		.divisor   (dvs_b1),
		.in_tag    ({neg_b1, flags_b1}),
		.out_valid (v_d1),
		.quotient  (q_d1),
		.out_tag   (tag_d1)
	);

	assign res_d1 = tag_d1[4] ? TW'(-q_d1) : q_d1;
	assign mag_d1 = res_d1[TW-1] ? TW'(-res_d1) : res_d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b2 <= 1'b0;
		end else begin
			v_b2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		neg_b2   <= res_d1[TW-1];
		mag_b2   <= mag_d1;
		flags_b2 <= tag_d1[3:0];
	end

	// Divide the magnitude by 3600 one byte per stage, top byte first
	assign hv_s[0]   = v_b2;
	assign hnum_s[0] = NB'(mag_b2);
	assign hrem_s[0] = '0;
	assign htag_s[0] = {neg_b2, flags_b2};

	for (genvar k = 0; k < ND; k++) begin : g_hour
		logic [RW+DG-1:0]                 cat;
		logic [hmsa_pkg::HOUR_PROD_W-1:0] hprod;
		logic [DG-1:0]                    qd;
		logic [RW+DG-1:0]                 sub;

		assign cat   = {hrem_s[k], hnum_s[k][NB-1 -: DG]};
		assign hprod = hmsa_pkg::HOUR_PROD_W'(cat[RW+DG-1:PS])
			* hmsa_pkg::HOUR_PROD_W'(hmsa_pkg::HOUR_RECIP);
		assign qd    = hprod[hmsa_pkg::HOUR_RECIP_SHIFT +: DG];
		assign sub   = cat - (RW+DG)'(qd) * (RW+DG)'(hmsa_pkg::SEC_PER_HOUR);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[k+1] <= 1'b0;
			end else begin
				hv_s[k+1] <= hv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			hnum_s[k+1] <= {hnum_s[k][NB-DG-1:0], qd};
			hrem_s[k+1] <= sub[RW-1:0];
			htag_s[k+1] <= htag_s[k];
		end
	end

	assign hrs_signed = htag_s[ND][4] ? NB'(-hnum_s[ND]) : hnum_s[ND];
	assign min_prod   = hmsa_pkg::MIN_PROD_W'(hrem_s[ND])
		* hmsa_pkg::MIN_PROD_W'(hmsa_pkg::MIN_RECIP);
	assign mins       = min_prod[hmsa_pkg::MIN_RECIP_SHIFT +: 6];
	assign secs       = hrem_s[ND] - RW'(mins) * RW'(hmsa_pkg::SEC_PER_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hv_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		hours_q   <= hrs_signed[20:0];
		minutes_q <= htag_s[ND][4] ? 7'(-{1'b0, mins}) : {1'b0, mins};
		seconds_q <= htag_s[ND][4] ? 7'(-secs[6:0]) : secs[6:0];
		flags_q   <= htag_s[ND][3:0];
	end

	assign done        = done_q;
	assign res_hours   = hours_q;
	assign res_minutes = minutes_q;
	assign res_seconds = seconds_q;
	assign res_flags   = flags_q;
endmodule

@@ rtl/hmsa_checker.sv @@
// Port-level checks for the time arithmetic unit and their binding
module hmsa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              done,
	input logic signed [20:0] res_hours,
	input logic signed [6:0] res_minutes,
	input logic signed [6:0] res_seconds,
	input logic              a_greater,
	input logic              a_less,
	input logic              a_equal,
	input logic              div_by_zero
);
	a_no_done_in_reset: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("result strobe during reset");

	a_one_compare: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({a_greater, a_less, a_equal}))
		else $error("compare flags not exclusive");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_by_zero |-> res_hours == 21'sd0 && res_minutes == 7'sd0
			&& res_seconds == 7'sd0)
		else $error("divide by zero gave a non-zero time");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res_minutes >= -7'sd59 && res_minutes <= 7'sd59
			&& res_seconds >= -7'sd59 && res_seconds <= 7'sd59)
		else $error("minutes or seconds out of range");

	a_sign_agree: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res_minutes < 7'sd0 && res_seconds > 7'sd0)
			&& !(res_minutes > 7'sd0 && res_seconds < 7'sd0))
		else $error("minutes and seconds disagree in sign");
endmodule

bind hms_time_arithmetic_unit hmsa_checker u_hmsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.done        (done),
	.res_hours   (res_hours),
	.res_minutes (res_minutes),
	.res_seconds (res_seconds),
	.a_greater   (a_greater),
	.a_less      (a_less),
	.a_equal     (a_equal),
	.div_by_zero (div_by_zero)
);
